@@ rtl/ocl_pkg.sv @@
// Shared types and constants for the on/off command line recogniser.
`default_nettype none

package ocl_pkg;

    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 104;
    localparam int unsigned COUNT_W    = 32;

    localparam logic [1:0] FUNC_SERIAL  = 2'd0;
    localparam logic [1:0] FUNC_REMOTE  = 2'd1;
    localparam logic [1:0] FUNC_CONSUME = 2'd2;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_UP_N  = 8'h4E;
    localparam logic [7:0] CHAR_UP_O  = 8'h4F;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;
    localparam logic [7:0] CHAR_LO_N  = 8'h6E;
    localparam logic [7:0] CHAR_LO_O  = 8'h6F;

    // outcome of a newline, valid only on the accepted serial transfer
    typedef struct packed {
        logic cmd;
        logic cmd_on;
        logic unknown;
    } t_line_evt;

    // last field in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0] unknown_count;
        logic [COUNT_W-1:0] remote_count;
        logic [COUNT_W-1:0] serial_count;
        logic               consume_value;
        logic               consume_valid;
        logic               request_value;
        logic               request_pending;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/ocl_line_match.sv @@
// Running token matcher: classifies a serial line as it arrives, no line store.
`default_nettype none

module ocl_line_match #(
    parameter int unsigned LINE_BUFFER_SIZE = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wire [7:0]            i_byte,
    output ocl_pkg::t_line_evt   o_evt
);

    localparam int unsigned LEN_W = $clog2(LINE_BUFFER_SIZE);
    localparam logic [LEN_W-1:0] DEPTH = LEN_W'(LINE_BUFFER_SIZE - 1);

    typedef enum logic [2:0] {
        TOK_NONE,
        TOK_O,
        TOK_ON,
        TOK_OF,
        TOK_OFF,
        TOK_ONE,
        TOK_ZERO,
        TOK_BAD
    } t_tok;

    t_tok             r_tok, n_tok, tok_step;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_zero, n_zero;
    logic             r_gap, n_gap;
    logic             is_nl, is_cr, is_blank, take;
    logic             up_o, up_n, up_f;

    assign is_nl    = (i_byte == ocl_pkg::CHAR_LF);
    assign is_cr    = (i_byte == ocl_pkg::CHAR_CR);
    assign is_blank = (i_byte == ocl_pkg::CHAR_SPACE) || (i_byte == ocl_pkg::CHAR_TAB);
    assign take     = !is_nl && !is_cr && (r_len < DEPTH);
    assign up_o     = (i_byte == ocl_pkg::CHAR_UP_O) || (i_byte == ocl_pkg::CHAR_LO_O);
    assign up_n     = (i_byte == ocl_pkg::CHAR_UP_N) || (i_byte == ocl_pkg::CHAR_LO_N);
    assign up_f     = (i_byte == ocl_pkg::CHAR_UP_F) || (i_byte == ocl_pkg::CHAR_LO_F);

    always_comb begin
        case (r_tok)
            TOK_NONE: begin
                if (up_o) tok_step = TOK_O;
                else if (i_byte == ocl_pkg::CHAR_ONE) tok_step = TOK_ONE;
                else if (i_byte == ocl_pkg::CHAR_ZERO) tok_step = TOK_ZERO;
                else tok_step = TOK_BAD;
            end
            TOK_O: begin
                if (up_n) tok_step = TOK_ON;
                else if (up_f) tok_step = TOK_OF;
                else tok_step = TOK_BAD;
            end
            TOK_OF: begin
                tok_step = up_f ? TOK_OFF : TOK_BAD;
            end
            default: begin
                tok_step = TOK_BAD;
            end
        endcase
    end

    always_comb begin
        o_evt.cmd     = i_valid && is_nl &&
                        (r_tok == TOK_ON || r_tok == TOK_ONE ||
                         r_tok == TOK_OFF || r_tok == TOK_ZERO);
        o_evt.cmd_on  = (r_tok == TOK_ON) || (r_tok == TOK_ONE);
        o_evt.unknown = i_valid && is_nl &&
                        (r_tok == TOK_O || r_tok == TOK_OF || r_tok == TOK_BAD);
    end

    always_comb begin
        n_tok  = r_tok;
        n_len  = r_len;
        n_zero = r_zero;
        n_gap  = r_gap;
        if (is_nl) begin
            n_tok  = TOK_NONE;
            n_len  = '0;
            n_zero = 1'b0;
            n_gap  = 1'b0;
        end else if (take) begin
            n_len = r_len + 1'b1;
            if (!r_zero) begin
                if (i_byte == ocl_pkg::CHAR_NUL) begin
                    n_zero = 1'b1;
                end else if (is_blank) begin
                    if (r_tok != TOK_NONE) n_gap = 1'b1;
                end else if (r_gap) begin
                    n_tok = TOK_BAD;
                end else begin
                    n_tok = tok_step;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= TOK_NONE;
            r_len  <= '0;
            r_zero <= 1'b0;
            r_gap  <= 1'b0;
        end else if (i_valid) begin
            r_tok  <= n_tok;
            r_len  <= n_len;
            r_zero <= n_zero;
            r_gap  <= n_gap;
        end
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= DEPTH)
        else $error("line length beyond store depth");

    a_nl_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && is_nl) |=> (r_len == '0 && r_tok == TOK_NONE && !r_gap))
        else $error("newline did not restart the line");

    a_evt_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_evt.cmd && o_evt.unknown))
        else $error("line judged both command and unknown");

    a_gap_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gap |-> (r_tok != TOK_NONE))
        else $error("trailing gap without a token");

endmodule

`default_nettype wire

@@ rtl/onoff_command_line_recognizer_core.sv @@
// Top level of the on/off command line recogniser.
//
// Input stream: i_s_tuser carries func (0 serial byte, 1 remote event,
// 2 consume), i_s_tdata carries rx_byte and remote_on. Every accepted
// transfer yields exactly one result transfer on the output stream, in order.
// A line is classified on the fly as its bytes arrive, so a newline is judged
// in the same cycle it is accepted; no line buffer is read back.
// The result is registered, not passed through combinationally.
// Throughput: one transfer per cycle, sustained while the receiver takes
// results; the state update is a single registered pass.
// The output side has a result register plus one skid entry: while the
// receiver stalls, one more input is taken into the skid, then o_s_tready
// drops until the receiver drains a result.
// Reset (synchronous, active low) clears the pending request, the three
// counters, the line state and both output entries.
`default_nettype none

module onoff_command_line_recognizer_core #(
    parameter int unsigned LINE_BUFFER_SIZE = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    // [7:0] rx_byte, [8] remote_on, [15:9] zero
    input  wire [ocl_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // [1:0] func
    input  wire [ocl_pkg::IN_USER_W-1:0]     i_s_tuser,
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    // [0] request_pending, [1] request_value, [2] consume_valid,
    // [3] consume_value, [35:4] serial_count, [67:36] remote_count,
    // [99:68] unknown_count, [103:100] zero
    output logic [ocl_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    localparam int unsigned RES_W = $bits(ocl_pkg::t_result);

    logic                    acc, pop;
    logic [1:0]              func;
    logic [7:0]              rx_byte;
    logic                    remote_on;
    ocl_pkg::t_line_evt      evt;
    ocl_pkg::t_result        res;

    logic                        r_pend_flag, n_pend_flag;
    logic                        r_pend_value, n_pend_value;
    logic [ocl_pkg::COUNT_W-1:0] r_serial_cnt, n_serial_cnt;
    logic [ocl_pkg::COUNT_W-1:0] r_remote_cnt, n_remote_cnt;
    logic [ocl_pkg::COUNT_W-1:0] r_unknown_cnt, n_unknown_cnt;
    logic                        cons_valid, cons_value;

    ocl_pkg::t_result r_out, r_skid;
    logic             r_out_valid, r_skid_valid;

    assign func      = i_s_tuser;
    assign rx_byte   = i_s_tdata[7:0];
    assign remote_on = i_s_tdata[8];

    assign o_s_tready = !r_skid_valid;
    assign acc        = i_s_tvalid && o_s_tready;
    assign pop        = r_out_valid && i_m_tready;

    ocl_line_match #(
        .LINE_BUFFER_SIZE(LINE_BUFFER_SIZE)
    ) u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (acc && (func == ocl_pkg::FUNC_SERIAL)),
        .i_byte  (rx_byte),
        .o_evt   (evt)
    );

    always_comb begin
        n_pend_flag   = r_pend_flag;
        n_pend_value  = r_pend_value;
        n_serial_cnt  = r_serial_cnt;
        n_remote_cnt  = r_remote_cnt;
        n_unknown_cnt = r_unknown_cnt;
        cons_valid    = 1'b0;
        cons_value    = 1'b0;
        case (func)
            ocl_pkg::FUNC_SERIAL: begin
                if (evt.cmd) begin
                    n_pend_flag  = 1'b1;
                    n_pend_value = evt.cmd_on;
                    n_serial_cnt = r_serial_cnt + 1'b1;
                end
                if (evt.unknown) n_unknown_cnt = r_unknown_cnt + 1'b1;
            end
            ocl_pkg::FUNC_REMOTE: begin
                n_pend_flag  = 1'b1;
                n_pend_value = remote_on;
                n_remote_cnt = r_remote_cnt + 1'b1;
            end
            ocl_pkg::FUNC_CONSUME: begin
                if (r_pend_flag) begin
                    cons_valid  = 1'b1;
                    cons_value  = r_pend_value;
                    n_pend_flag = 1'b0;
                end
            end
            default: begin
            end
        endcase
        res.request_pending = n_pend_flag;
        res.request_value   = n_pend_value;
        res.consume_valid   = cons_valid;
        res.consume_value   = cons_value;
        res.serial_count    = n_serial_cnt;
        res.remote_count    = n_remote_cnt;
        res.unknown_count   = n_unknown_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_flag   <= 1'b0;
            r_pend_value  <= 1'b0;
            r_serial_cnt  <= '0;
            r_remote_cnt  <= '0;
            r_unknown_cnt <= '0;
        end else if (acc) begin
            r_pend_flag   <= n_pend_flag;
            r_pend_value  <= n_pend_value;
            r_serial_cnt  <= n_serial_cnt;
            r_remote_cnt  <= n_remote_cnt;
            r_unknown_cnt <= n_unknown_cnt;
        end
    end

    // result register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= acc;
            end
        end else if (acc) begin
            if (r_out_valid) r_skid_valid <= 1'b1;
            else r_out_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) r_out <= r_skid;
            else if (acc) r_out <= res;
        end else if (acc) begin
            if (r_out_valid) r_skid <= res;
            else r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(ocl_pkg::OUT_DATA_W - RES_W)'(0), r_out};

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a result in front");

    a_consume_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && func == ocl_pkg::FUNC_CONSUME) |=> !r_pend_flag)
        else $error("consume left a request pending");

    a_remote_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && func == ocl_pkg::FUNC_REMOTE) |=>
        (r_remote_cnt == $past(r_remote_cnt) + 1'b1) && r_pend_flag)
        else $error("remote event not counted");

    a_counts_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> ($stable(r_serial_cnt) && $stable(r_unknown_cnt) &&
                  $stable(r_remote_cnt)))
        else $error("counter moved without a transfer");

endmodule

`default_nettype wire
